// ----- rtl/core/md5_pkg.sv -----
// md5_pkg: shared types, constants and round tables for the md5 stream hasher
// no dependencies
`default_nettype none
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam int unsigned LEN_POS = 56;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_number;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    // byte source for a store write
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } t_byte_src;

    typedef struct packed {
        logic      take_item;    // accept input item, count its byte (if any) in length
        logic      put_byte;     // write one byte at fill position
        t_byte_src byte_src;
        logic      round_start;  // load working regs from chain
        logic      round_step;   // one compression round
        logic      fold;         // add working regs into chain
        logic      snap_len;     // latch bit length for padding
        logic      clear_all;    // return to initial values
        logic      out_load;     // load output register with word
        logic [1:0] out_sel;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round;
    } t_status;

    function automatic logic [31:0] round_add(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
        };
        return k[r];
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s [16];
        s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return s[{r[5:4], r[1:0]}];
    endfunction

    function automatic logic [3:0] word_index(input logic [5:0] r);
        logic [3:0] i;
        i = r[3:0];
        case (r[5:4])
            2'd0: word_index = i;
            2'd1: word_index = 4'((i << 2) + i + 4'd1);
            2'd2: word_index = 4'((i << 1) + i + 4'd5);
            default: word_index = 4'((i << 3) - i);
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/md5_ctrl.sv -----
// md5_ctrl: sequencer for byte intake, padding, 64 rounds and digest output
// depends on md5_pkg
`default_nettype none
module md5_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  md5_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output md5_pkg::t_cmd       o_cmd,
    input  md5_pkg::t_status    i_status
);

    md5_pkg::t_state r_state, n_state;
    logic            r_final, n_final;     // padding pending after compression
    logic            r_len_done, n_len_done;
    logic [1:0]      r_word, n_word;
    logic            r_out_valid, n_out_valid;
    logic            r_mark_done, n_mark_done;
    logic            r_len_ok, n_len_ok;   // length bytes go into the current pad block
    logic            accept, out_take;
    logic            len_zone;

    assign o_in_stall  = (r_state != md5_pkg::ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign len_zone    = (i_status.fill >= 6'(md5_pkg::LEN_POS));

    // next state
    always_comb begin
        n_state     = r_state;
        n_final     = r_final;
        n_len_done  = r_len_done;
        n_word      = r_word;
        n_out_valid = r_out_valid;
        n_mark_done = r_mark_done;
        n_len_ok    = r_len_ok;
        case (r_state)
            md5_pkg::ST_IDLE: begin
                if (accept) begin
                    n_final     = i_in_item.end_of_message;
                    n_len_done  = 1'b0;
                    n_mark_done = 1'b0;
                    if (i_in_item.has_byte && i_status.fill == 6'd63) begin
                        n_state = md5_pkg::ST_ROUND;
                    end else if (i_in_item.end_of_message) begin
                        n_state = md5_pkg::ST_PAD;
                    end
                end
            end
            md5_pkg::ST_ROUND: begin
                if (i_status.round == 6'd63) begin
                    n_state = md5_pkg::ST_FOLD;
                end
            end
            md5_pkg::ST_FOLD: begin
                if (!r_final) begin
                    n_state = md5_pkg::ST_IDLE;
                end else if (r_len_done) begin
                    n_state     = md5_pkg::ST_OUT;
                    n_word      = 2'd0;
                    n_out_valid = 1'b0;
                end else begin
                    n_state = md5_pkg::ST_PAD;
                end
            end
            md5_pkg::ST_PAD: begin
                n_mark_done = 1'b1;
                // marker in the last slot leaves a fresh block for the length
                if (!r_mark_done) begin
                    n_len_ok = (i_status.fill < 6'(md5_pkg::LEN_POS))
                               || (i_status.fill == 6'd63);
                end
                if (i_status.fill == 6'd63) begin
                    n_state = md5_pkg::ST_ROUND;
                    if (r_mark_done) begin
                        if (r_len_ok) begin
                            n_len_done = 1'b1;
                        end else begin
                            n_len_ok = 1'b1;
                        end
                    end
                end
            end
            md5_pkg::ST_OUT: begin
                if (!r_out_valid || out_take) begin
                    if (r_out_valid && r_word == 2'd3) begin
                        n_out_valid = 1'b0;
                        n_state     = md5_pkg::ST_IDLE;
                    end else begin
                        n_out_valid = 1'b1;
                        if (r_out_valid) n_word = r_word + 2'd1;
                    end
                end
            end
            default: n_state = md5_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.byte_src = md5_pkg::SRC_INPUT;
        o_cmd.out_sel  = n_word;
        case (r_state)
            md5_pkg::ST_IDLE: begin
                o_cmd.take_item = accept;
                o_cmd.put_byte  = accept && i_in_item.has_byte;
                o_cmd.snap_len  = accept;
                o_cmd.round_start = accept && i_in_item.has_byte
                                    && i_status.fill == 6'd63;
            end
            md5_pkg::ST_ROUND: begin
                o_cmd.round_step = 1'b1;
            end
            md5_pkg::ST_FOLD: begin
                o_cmd.fold = 1'b1;
            end
            md5_pkg::ST_PAD: begin
                o_cmd.put_byte = 1'b1;
                if (!r_mark_done) begin
                    o_cmd.byte_src = md5_pkg::SRC_MARK;
                end else if (len_zone && r_len_ok) begin
                    o_cmd.byte_src = md5_pkg::SRC_LEN;
                end else begin
                    o_cmd.byte_src = md5_pkg::SRC_ZERO;
                end
                o_cmd.round_start = (i_status.fill == 6'd63);
            end
            md5_pkg::ST_OUT: begin
                o_cmd.out_load  = !r_out_valid || out_take;
                o_cmd.clear_all = out_take && r_word == 2'd3;
            end
            default: o_cmd.put_byte = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= md5_pkg::ST_IDLE;
            r_final     <= 1'b0;
            r_len_done  <= 1'b0;
            r_word      <= 2'd0;
            r_out_valid <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_ok    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_final     <= n_final;
            r_len_done  <= n_len_done;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
            r_mark_done <= n_mark_done;
            r_len_ok    <= n_len_ok;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/md5_dpath.sv -----
// md5_dpath: block store, length counter, round unit and chaining words
// depends on md5_pkg
`default_nettype none
module md5_dpath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  md5_pkg::t_in_item   i_in_item,
    input  md5_pkg::t_cmd       i_cmd,
    output md5_pkg::t_status    o_status,
    output md5_pkg::t_out_item  o_out_item
);

    logic [31:0] r_store [16];   // block as 16 little-endian words
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_round;
    md5_pkg::t_out_item r_out;

    logic [7:0]  wr_byte;
    logic [31:0] mix, sum, rot, w;
    logic [3:0]  widx;
    logic [4:0]  sh;
    logic [2:0]  lsel;

    assign lsel = r_fill[2:0];

    always_comb begin
        case (i_cmd.byte_src)
            md5_pkg::SRC_INPUT: wr_byte = i_in_item.data_byte;
            md5_pkg::SRC_MARK:  wr_byte = md5_pkg::PAD_MARK;
            md5_pkg::SRC_LEN:   wr_byte = r_len[8*lsel +: 8];
            default:            wr_byte = 8'h00;
        endcase
    end

    // round logic
    always_comb begin
        case (r_round[5:4])
            2'd0: mix = r_d ^ (r_b & (r_c ^ r_d));
            2'd1: mix = r_c ^ (r_d & (r_b ^ r_c));
            2'd2: mix = r_b ^ r_c ^ r_d;
            default: mix = r_c ^ (r_b | ~r_d);
        endcase
        widx = md5_pkg::word_index(r_round);
        w    = r_store[widx];
        sh   = md5_pkg::rot_amount(r_round);
        sum  = r_a + mix + md5_pkg::round_add(r_round) + w;
        rot  = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    assign o_status.fill       = r_fill;
    assign o_status.round      = r_round;
    assign o_out_item          = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_byte) begin
            r_store[r_fill[5:2]][{r_fill[1:0], 3'b000} +: 8] <= wr_byte;
        end
        if (i_cmd.round_start) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_cmd.round_step) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
        if (i_cmd.out_load) begin
            r_out.digest_word <= r_chain[i_cmd.out_sel];
            r_out.word_number <= i_cmd.out_sel;
            r_out.last_word   <= (i_cmd.out_sel == 2'd3);
        end
        if (i_cmd.snap_len) begin
            r_len <= r_bits + (i_in_item.has_byte ? 64'd8 : 64'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_fill     <= '0;
            r_bits     <= '0;
            r_round    <= '0;
            r_chain[0] <= md5_pkg::INIT_A;
            r_chain[1] <= md5_pkg::INIT_B;
            r_chain[2] <= md5_pkg::INIT_C;
            r_chain[3] <= md5_pkg::INIT_D;
        end else begin
            if (i_cmd.put_byte) r_fill <= r_fill + 6'd1;
            if (i_cmd.take_item && i_in_item.has_byte) r_bits <= r_bits + 64'd8;
            if (i_cmd.round_step) r_round <= r_round + 6'd1;
            if (i_cmd.fold) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/md5_stream_hasher.sv -----
// md5_stream_hasher: at most one message byte per item, md5 digest out as four words
// an item that fills a block stalls input through the 64 rounds and the fold
// end of message: padding bytes one a cycle, each 64th followed by compression
// (one or two blocks), the output register load, then four digest items one a cycle
// when not stalled; other items are taken one a cycle while idle
// reset: synchronous active low, chain words to md5 initial values, counters cleared
`default_nettype none
module md5_stream_hasher (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  md5_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output md5_pkg::t_out_item  o_out_item
);

    md5_pkg::t_cmd    cmd;
    md5_pkg::t_status status;

    md5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    md5_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule
`default_nettype wire

// ----- tb/md5_stream_hasher_tb.sv -----
// md5_stream_hasher_tb: self-checking testbench for the streaming md5 hasher
// drives byte items with random gaps, predicts digests with its own md5 model
// depends on md5_pkg and md5_stream_hasher
`default_nettype none
module md5_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    md5_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    md5_pkg::t_out_item o_out_item;

    md5_stream_hasher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    // predictor state
    logic [31:0] hash_chain [4];
    logic [7:0]  msg_block [64];
    logic [5:0]  msg_fill;
    logic [63:0] msg_bits;

    md5_pkg::t_in_item  pending_items [$];
    md5_pkg::t_out_item digest_queue [$];
    int        mismatch_count;
    bit        flush_wait;     // sender holds until digests drained
    int        hold_cycles;    // long receiver hold-off request
    bit        in_accepted;    // input item taken at the last rising edge
    bit        out_accepted;   // output item taken at the last rising edge

    localparam logic [31:0] ADD_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int SHIFT_TABLE [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                        4, 11, 16, 23, 6, 10, 15, 21};

    task automatic restart_hash();
        hash_chain[0] = md5_pkg::INIT_A;
        hash_chain[1] = md5_pkg::INIT_B;
        hash_chain[2] = md5_pkg::INIT_C;
        hash_chain[3] = md5_pkg::INIT_D;
        msg_fill = '0;
        msg_bits = '0;
    endtask

    task automatic compress_msg_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t, s;
        int g;
        for (int k = 0; k < 16; k++)
            w[k] = {msg_block[4*k+3], msg_block[4*k+2], msg_block[4*k+1], msg_block[4*k]};
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin f = d ^ (b & (c ^ d)); g = r; end
                1: begin f = c ^ (d & (b ^ c)); g = (5*r + 1) % 16; end
                2: begin f = b ^ c ^ d;         g = (3*r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7*r) % 16; end
            endcase
            s = a + f + ADD_TABLE[r] + w[g];
            t = d; d = c; c = b;
            b = b + ((s << SHIFT_TABLE[(r/16)*4 + r%4]) |
                     (s >> (32 - SHIFT_TABLE[(r/16)*4 + r%4])));
            a = t;
        end
        hash_chain[0] += a; hash_chain[1] += b;
        hash_chain[2] += c; hash_chain[3] += d;
    endtask

    task automatic append_byte(input logic [7:0] v);
        msg_block[msg_fill] = v;
        msg_fill++;
        if (msg_fill == 0) compress_msg_block();
    endtask

    task automatic predict_digest(input md5_pkg::t_in_item it);
        logic [63:0] len;
        md5_pkg::t_out_item o;
        if (it.has_byte) begin
            append_byte(it.data_byte);
            msg_bits += 64'd8;
        end
        if (it.end_of_message) begin
            len = msg_bits;
            append_byte(md5_pkg::PAD_MARK);
            if (msg_fill > md5_pkg::LEN_POS)
                while (msg_fill != 0) append_byte(8'h00);
            while (msg_fill < md5_pkg::LEN_POS) append_byte(8'h00);
            for (int k = 0; k < 8; k++) append_byte(len[8*k +: 8]);
            for (int k = 0; k < 4; k++) begin
                o.digest_word = hash_chain[k];
                o.word_number = 2'(k);
                o.last_word   = (k == 3);
                digest_queue.push_back(o);
            end
            restart_hash();
        end
    endtask

    function automatic md5_pkg::t_in_item make_item(input logic [7:0] v, input bit hb,
                                                    input bit eom);
        md5_pkg::t_in_item it;
        it.data_byte = v;
        it.has_byte = hb;
        it.end_of_message = eom;
        return it;
    endfunction

    task automatic queue_message(input int n, input bit end_byte);
        for (int k = 0; k < n; k++)
            pending_items.push_back(make_item(8'($urandom), 1'b1, 1'b0));
        pending_items.push_back(make_item(8'($urandom), end_byte, 1'b1));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: one item at a time from the pending queue, random gaps
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else if (i_in_valid && !in_accepted) begin
            // hold payload while stalled
        end else begin
            if (i_in_valid) begin
                void'(pending_items.pop_front());
                send_gap = $urandom_range(0, 6);
            end
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0 && !flush_wait) begin
                i_in_valid <= 1'b1;
                i_in_item <= pending_items[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: random per item, or a long hold-off when requested
    int recv_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_gap = 0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            if (out_accepted) recv_gap = $urandom_range(0, 6);
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // accepted inputs feed the predictor, accepted outputs get checked
    always @(posedge i_clk) begin
        md5_pkg::t_out_item exp_item;
        in_accepted  = i_rst_n && i_in_valid && !o_in_stall;
        out_accepted = i_rst_n && o_out_valid && !i_out_stall;
        if (in_accepted) predict_digest(i_in_item);
        if (out_accepted) begin
            if (digest_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected digest item: exp none got %h", o_out_item);
            end else begin
                exp_item = digest_queue.pop_front();
                if (o_out_item.digest_word !== exp_item.digest_word ||
                    o_out_item.word_number !== exp_item.word_number ||
                    o_out_item.last_word !== exp_item.last_word) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 exp_item.digest_word, exp_item.word_number,
                                 exp_item.last_word, o_out_item.digest_word,
                                 o_out_item.word_number, o_out_item.last_word);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("md5_stream_hasher regression: fail");
        $finish;
    end

    initial begin
        int len;
        mismatch_count = 0;
        flush_wait = 1'b0;
        hold_cycles = 0;
        in_accepted = 1'b0;
        out_accepted = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        restart_hash();
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty message, extreme bytes, padding boundaries
        pending_items.push_back(make_item(8'h00, 1'b0, 1'b1));
        pending_items.push_back(make_item(8'hff, 1'b1, 1'b1));
        pending_items.push_back(make_item(8'h00, 1'b1, 1'b1));
        pending_items.push_back(make_item(8'h55, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'haa, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h3c, 1'b0, 1'b0));   // no byte, no end
        pending_items.push_back(make_item(8'hc3, 1'b0, 1'b1));
        // padding overflow: 56 and 63 bytes, full block with a byteless end item
        queue_message(55, 1'b1);
        queue_message(62, 1'b1);
        queue_message(64, 1'b0);
        wait (pending_items.size() == 0);

        // drain before continuing
        flush_wait = 1'b1;
        wait (digest_queue.size() == 0);
        flush_wait = 1'b0;

        // long receiver hold-off while several short messages go in
        hold_cycles = 400;
        for (int m = 0; m < 4; m++) queue_message($urandom_range(0, 5), $urandom_range(0, 1));

        // random messages, mostly short, a few past one block
        for (int m = 0; m < 10; m++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 20);
            for (int k = 0; k < len; k++)
                pending_items.push_back(make_item(8'($urandom), $urandom_range(0, 9) != 0,
                                                  1'b0));
            pending_items.push_back(make_item(8'($urandom), $urandom_range(0, 1), 1'b1));
        end
        wait (pending_items.size() == 0);
        wait (digest_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && digest_queue.size() == 0)
            $display("md5_stream_hasher regression: pass");
        else
            $display("md5_stream_hasher regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/md5_pkg.sv
rtl/core/md5_ctrl.sv
rtl/core/md5_dpath.sv
rtl/core/md5_stream_hasher.sv
tb/md5_stream_hasher_tb.sv
